// ----- rtl/gtgc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtgc_pkg
// Shared widths, register indexes and chain control type for the gyro twist
// gesture counter.
// ----------------------------------------------------------------------------
package gtgc_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int MAG_W      = 32;
  localparam int RATE_W     = 16;
  localparam int TIME_W     = 32;
  localparam int THR_W      = 15;
  localparam int MS_W       = 16;
  localparam int LEN_W      = 6;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CNT_W      = 4;

  localparam int WIN_IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = FILL_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP_MS        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIMEOUT_MS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH     = 2'd3;

  localparam logic [THR_W-1:0] RST_RATE_THRESHOLD    = 15'd12000;
  localparam logic [MS_W-1:0]  RST_MIN_GAP_MS        = 16'd200;
  localparam logic [MS_W-1:0]  RST_SETTLE_TIMEOUT_MS = 16'd1000;
  localparam logic [LEN_W-1:0] RST_WINDOW_LENGTH     = 6'd25;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  typedef struct packed {
    logic shift;   // load a new magnitude at the head
    logic rotate;  // tail wraps round to the head
  } chain_ctrl_t;

endpackage

// ----- rtl/gtgc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtgc_cell
// One window cell: holds a squared magnitude, takes its neighbour's value
// when the chain moves.
// ----------------------------------------------------------------------------
module gtgc_cell
  import gtgc_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [MAG_W-1:0] d_in,
  output logic [MAG_W-1:0] q
);

  logic [MAG_W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= d_in;
    end
  end

  assign q = val_r;

endmodule

// ----- rtl/gtgc_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtgc_chain
// Row of window cells, newest at the head. Shifts a new magnitude in, or
// rotates so every entry passes the tail once per scan.
// ----------------------------------------------------------------------------
module gtgc_chain
  import gtgc_pkg::*;
(
  input  logic             clk,
  input  chain_ctrl_t      ctrl,
  input  logic [MAG_W-1:0] new_mag,
  output logic [MAG_W-1:0] tail
);

  logic [MAG_W-1:0] q [MAX_WINDOW];
  logic             en;

  assign en   = ctrl.shift | ctrl.rotate;
  assign tail = q[MAX_WINDOW-1];

  gtgc_cell u_cell_head (
    .clk  (clk),
    .en   (en),
    .d_in (ctrl.rotate ? tail : new_mag),
    .q    (q[0])
  );

  for (genvar k = 1; k < MAX_WINDOW; k++) begin : g_cell
    gtgc_cell u_cell (
      .clk  (clk),
      .en   (en),
      .d_in (q[k-1]),
      .q    (q[k])
    );
  end

endmodule

// ----- rtl/gyro_twist_gesture_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_twist_gesture_counter
// Squared gyro magnitude into a sliding window, peak against squared
// threshold, twist counting with gap and settle timing, sticky gesture flags.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   in      | in_valid/in_ready, in_*        | sink
//   out     | out_valid/out_ready, out_*     | source
//   cfg     | cfg_we, cfg_index, cfg_wdata   | sink
//
// A sample goes through the squaring states MULX, MULY and MULT on one
// shared multiplier, one shift, then a full rotation of the cell chain with
// the peak taken at the tail. A reinitialise beat goes straight to decision.
// One beat in flight at a time; a result waits in the output register while
// the next beat is accepted and worked on.
// Synchronous active-low reset restores the register defaults.
// ----------------------------------------------------------------------------
module gyro_twist_gesture_counter
  import gtgc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_req_type,
  input  logic signed [RATE_W-1:0] in_rate_x,
  input  logic signed [RATE_W-1:0] in_rate_y,
  input  logic [TIME_W-1:0]        in_now_ms,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_twist_event,
  output logic [CNT_W-1:0]         out_pending_count,
  output logic                     out_single_flag,
  output logic                     out_double_flag,
  output logic                     out_triple_flag,
  output logic [MAG_W-1:0]         out_peak_square,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MULX   = 3'd1;
  localparam logic [2:0] ST_MULY   = 3'd2;
  localparam logic [2:0] ST_MULT   = 3'd3;
  localparam logic [2:0] ST_SHIFT  = 3'd4;
  localparam logic [2:0] ST_SCAN   = 3'd5;
  localparam logic [2:0] ST_DECIDE = 3'd6;

  logic [2:0]               state_r, state_nxt;

  logic [THR_W-1:0]         thr_r;
  logic [MS_W-1:0]          gap_r;
  logic [MS_W-1:0]          settle_r;
  logic [LEN_W-1:0]         len_cfg_r;

  logic                     type_r;
  logic signed [RATE_W-1:0] x_r, y_r;
  logic [TIME_W-1:0]        now_r;

  logic [MAG_W-1:0]         sqx_r, sqy_r, thr2_r, peak_r;
  logic [FILL_W-1:0]        fill_r;
  logic [WIN_IDX_W-1:0]     scan_r;
  logic [TIME_W-1:0]        last_r;
  logic [CNT_W-1:0]         count_r;
  logic                     above_r;
  logic [2:0]               flags_r;

  logic                     ov_r;
  logic                     ev_r;
  logic [MAG_W-1:0]         opeak_r;

  logic signed [RATE_W-1:0] mul_op;
  logic signed [MAG_W-1:0]  mul_prod;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W-1:0]         tail;
  chain_ctrl_t              ctrl;
  logic [FILL_W-1:0]        len_act;
  logic [FILL_W-1:0]        fill_new;
  logic                     in_win;
  logic                     slot_free;
  logic [TIME_W-1:0]        elapsed;
  logic                     above, gap_ok, event_c, settled;
  logic [CNT_W-1:0]         count_inc;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= RST_RATE_THRESHOLD;
      gap_r     <= RST_MIN_GAP_MS;
      settle_r  <= RST_SETTLE_TIMEOUT_MS;
      len_cfg_r <= RST_WINDOW_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATE_THRESHOLD:    thr_r     <= cfg_wdata[THR_W-1:0];
        CFG_MIN_GAP_MS:        gap_r     <= cfg_wdata[MS_W-1:0];
        CFG_SETTLE_TIMEOUT_MS: settle_r  <= cfg_wdata[MS_W-1:0];
        CFG_WINDOW_LENGTH:     len_cfg_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // shared squaring unit
  always_comb begin
    case (state_r)
      ST_MULX: mul_op = x_r;
      ST_MULY: mul_op = y_r;
      default: mul_op = $signed({1'b0, thr_r});
    endcase
  end
  assign mul_prod = mul_op * mul_op;
  assign mag      = sqx_r + sqy_r;

  // window length clamp and fill after append
  always_comb begin
    if (len_cfg_r == '0) begin
      len_act = FILL_W'(1);
    end else if (32'(len_cfg_r) > MAX_WINDOW) begin
      len_act = FILL_W'(MAX_WINDOW);
    end else begin
      len_act = FILL_W'(len_cfg_r);
    end
    fill_new = (fill_r < len_act) ? fill_r + FILL_W'(1) : fill_r;
  end

  assign ctrl.shift  = (state_r == ST_SHIFT);
  assign ctrl.rotate = (state_r == ST_SCAN);
  assign in_win      = (SUM_W'(scan_r) + SUM_W'(fill_r)) >= SUM_W'(MAX_WINDOW);

  gtgc_chain u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .new_mag (mag),
    .tail    (tail)
  );

  // twist decision
  assign elapsed   = now_r - last_r;
  assign above     = peak_r > thr2_r;
  assign gap_ok    = elapsed > TIME_W'(gap_r);
  assign event_c   = above && !above_r && gap_ok;
  assign settled   = !event_c && (elapsed > TIME_W'(settle_r));
  assign count_inc = (count_r < CNT_MAX) ? count_r + CNT_W'(1) : count_r;
  assign slot_free = !ov_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = in_req_type ? ST_DECIDE : ST_MULX;
      ST_MULX:   state_nxt = ST_MULY;
      ST_MULY:   state_nxt = ST_MULT;
      ST_MULT:   state_nxt = ST_SHIFT;
      ST_SHIFT:  state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_r == WIN_IDX_W'(MAX_WINDOW - 1)) state_nxt = ST_DECIDE;
      ST_DECIDE: if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      type_r <= in_req_type;
      x_r    <= in_rate_x;
      y_r    <= in_rate_y;
      now_r  <= in_now_ms;
    end
    case (state_r)
      ST_MULX: sqx_r  <= mul_prod;
      ST_MULY: sqy_r  <= mul_prod;
      ST_MULT: thr2_r <= mul_prod;
      default: ;
    endcase
    if (state_r == ST_SHIFT) begin
      peak_r <= '0;
    end else if (state_r == ST_SCAN && in_win && tail > peak_r) begin
      peak_r <= tail;
    end
    if (state_r == ST_DECIDE && slot_free) begin
      ev_r    <= type_r ? 1'b0 : event_c;
      opeak_r <= type_r ? '0 : peak_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scan_r  <= '0;
      fill_r  <= '0;
      last_r  <= '0;
      count_r <= '0;
      above_r <= 1'b0;
      flags_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ready) begin
        ov_r <= 1'b0;
      end
      if (state_r == ST_SHIFT) begin
        scan_r <= '0;
        fill_r <= fill_new;
      end else if (state_r == ST_SCAN) begin
        scan_r <= scan_r + WIN_IDX_W'(1);
      end
      if (state_r == ST_DECIDE && slot_free) begin
        ov_r <= 1'b1;
        if (type_r) begin
          fill_r  <= '0;
          flags_r <= '0;
        end else begin
          if (!above) begin
            above_r <= 1'b0;
          end
          if (event_c) begin
            above_r <= 1'b1;
            fill_r  <= '0;
            count_r <= count_inc;
            last_r  <= now_r;
          end
          if (settled) begin
            count_r <= '0;
            case (count_r)
              4'd1:    flags_r[0] <= 1'b1;
              4'd2:    flags_r[1] <= 1'b1;
              4'd3:    flags_r[2] <= 1'b1;
              default: ;
            endcase
          end
        end
      end
    end
  end

  assign out_valid         = ov_r;
  assign out_twist_event   = ev_r;
  assign out_pending_count = count_r;
  assign out_single_flag   = flags_r[0];
  assign out_double_flag   = flags_r[1];
  assign out_triple_flag   = flags_r[2];
  assign out_peak_square   = opeak_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != ST_IDLE)
    else $error("accepted beat did not start work");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && scan_r == WIN_IDX_W'(MAX_WINDOW - 1) |=> state_r == ST_DECIDE)
    else $error("scan overran the chain");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= MAX_WINDOW)
    else $error("window fill beyond chain length");

  a_event_counts: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ev_r |-> count_r != '0)
    else $error("twist reported with empty count");

  a_result_only_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    !ov_r ##1 ov_r |-> $past(state_r) == ST_DECIDE)
    else $error("result raised outside decision");

endmodule
